// ----- rtl/sop_pkg.sv -----
package sop_pkg;

    // Parser phases of one NAL unit.
    typedef enum logic [2:0] {
        PH_SEARCH  = 3'd0,
        PH_NAL     = 3'd1,
        PH_UUID    = 3'd2,
        PH_MARKER  = 3'd3,
        PH_FIELDS  = 3'd4,
        PH_OFFSETS = 3'd5,
        PH_IDLE    = 3'd6,
        PH_DONE    = 3'd7
    } t_phase;

    // Item operation codes.
    localparam logic OP_STREAM = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic [4:0] NAL_KIND_BITS = 5'h1f;
    localparam logic [4:0] NAL_KIND_SEI  = 5'd6;
    localparam logic [3:0] HEADER_LEN    = 4'd10;
    localparam logic [3:0] HDR_POS_SEQ   = 4'd6;
    localparam logic [3:0] HDR_POS_FRM   = 4'd7;
    localparam logic [4:0] UUID_LEN      = 5'd16;
    localparam logic [4:0] MARKER_END    = 5'd20;

    typedef logic [7:0] t_byte;

    localparam t_byte UUID_BYTES [16] = '{
        8'h17, 8'hee, 8'h8c, 8'h60, 8'hf8, 8'h4d, 8'h11, 8'hd9,
        8'h8c, 8'hd6, 8'h08, 8'h00, 8'h20, 8'h0c, 8'h9a, 8'h66
    };

    localparam t_byte MARKER_BYTES [4] = '{8'h4f, 8'h46, 8'h4d, 8'h44};

endpackage

// ----- rtl/sop_if.sv -----
// Input channel: one access unit byte or one offset read per transfer.
interface sop_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [5:0] sequence_index;
    logic [7:0] frame_index;

    modport source (output valid, operation, data_byte, last_byte,
                    sequence_index, frame_index, input ready);
    modport sink (input valid, operation, data_byte, last_byte,
                  sequence_index, frame_index, output ready);
endinterface

// Output channel: one result per accepted input item.
interface sop_out_if;
    logic              valid;
    logic              ready;
    logic              found;
    logic [5:0]        sequence_count;
    logic [7:0]        frame_count;
    logic signed [7:0] offset;

    modport source (output valid, found, sequence_count, frame_count, offset,
                    input ready);
    modport sink (input valid, found, sequence_count, frame_count, offset,
                  output ready);
endinterface

// ----- rtl/stereo_offset_sei_parser.sv -----
// Stereo offset metadata SEI parser.
// The input channel carries either one byte of an access unit (operation 0,
// last_byte marks the final byte) or a read of one committed offset
// (operation 1, sequence_index and frame_index). Every accepted item gives
// exactly one transfer on the output channel, in order.
// The result is registered: it sits in the output register in the cycle after
// the input transfer. One item is accepted every cycle; the limit is the
// single output register, so input ready falls only while a result is held
// and the receiver is stalling.
// Each byte item may feed up to four bytes into the parser (the start code
// delay line is flushed at the end of an access unit), so the offset table
// is split into four memories by the low two bits of the write position,
// and each memory takes at most one write per cycle. A read item reads the
// memory chosen by the low index bits; its data register feeds the output.
// Reset clears all control state and the committed counts to zero. The
// offset table is not cleared: only entries of a committed bank, all of
// which were written, are ever read. There is no clearing pass.
module stereo_offset_sei_parser #(
    parameter int MAX_SEQUENCES  = 32,
    parameter int MAX_UNIT_BYTES = 65536,
    parameter int TABLE_DEPTH    = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sop_in_if.sink      i_in,
    sop_out_if.source   o_out
);

    localparam int ULW        = $clog2(MAX_UNIT_BYTES + 2);
    localparam int WPW        = $clog2(TABLE_DEPTH + 1);
    localparam int LANE_DEPTH = (TABLE_DEPTH + 3) / 4;
    localparam int AW         = $clog2(2 * LANE_DEPTH);
    localparam int NLANES     = 4;
    localparam int NSLOTS     = 4;

    typedef struct packed {
        sop_pkg::t_phase phase;
        logic [ULW-1:0]  ulen;
        logic [1:0]      esc;
        logic [4:0]      pat;
        logic [3:0]      hdr;
        logic [5:0]      pseq;
        logic [7:0]      pfrm;
        logic [WPW-1:0]  wp;
        logic            pcomp;
        logic            udone;
        logic            abank;
        logic [5:0]      cseq;
        logic [7:0]      cfrm;
    } t_state;

    typedef struct packed {
        logic           we;
        logic           bank;
        logic [WPW-1:0] pos;
        logic [7:0]     val;
    } t_wr;

    // Parser step on one byte of the unescaped payload.
    function automatic t_state parse_rbsp(input t_state s, input logic [7:0] b,
                                          output t_wr w);
        t_state     n;
        logic [1:0] k;
        logic [13:0] prod;
        logic [6:0] mag;
        n = s;
        w = '0;
        prod = 14'(s.pseq) * 14'(s.pfrm);
        mag = b[6:0];
        case (s.phase)
            sop_pkg::PH_UUID: begin
                if (s.pat < sop_pkg::UUID_LEN && b == sop_pkg::UUID_BYTES[s.pat[3:0]])
                    n.pat = s.pat + 5'd1;
                else
                    n.pat = (b == sop_pkg::UUID_BYTES[0]) ? 5'd1 : 5'd0;
                if (n.pat >= sop_pkg::UUID_LEN) begin
                    n.pat = sop_pkg::UUID_LEN;
                    n.phase = sop_pkg::PH_MARKER;
                end
            end
            sop_pkg::PH_MARKER: begin
                k = 2'(s.pat - sop_pkg::UUID_LEN);
                if (b != sop_pkg::MARKER_BYTES[k]) begin
                    n.phase = sop_pkg::PH_IDLE;
                end else begin
                    n.pat = s.pat + 5'd1;
                    if (n.pat >= sop_pkg::MARKER_END) begin
                        n.phase = sop_pkg::PH_FIELDS;
                        n.hdr = '0;
                    end
                end
            end
            sop_pkg::PH_FIELDS: begin
                if (s.hdr == sop_pkg::HDR_POS_SEQ) n.pseq = b[5:0];
                if (s.hdr == sop_pkg::HDR_POS_FRM) n.pfrm = b;
                n.hdr = s.hdr + 4'd1;
                prod = 14'(n.pseq) * 14'(n.pfrm);
                if (n.hdr >= sop_pkg::HEADER_LEN) begin
                    if (n.pseq == '0 || 32'(n.pseq) > MAX_SEQUENCES || n.pfrm == '0 ||
                        32'(prod) > TABLE_DEPTH) begin
                        n.phase = sop_pkg::PH_IDLE;
                    end else begin
                        n.phase = sop_pkg::PH_OFFSETS;
                        n.wp = '0;
                    end
                end
            end
            sop_pkg::PH_OFFSETS: begin
                w.we = 1'b1;
                w.bank = ~s.abank;
                w.pos = s.wp;
                w.val = b[7] ? (8'd0 - {1'b0, mag}) : {1'b0, mag};
                n.wp = s.wp + WPW'(1);
                if (32'(n.wp) >= 32'(prod)) begin
                    n.pcomp = 1'b1;
                    n.phase = sop_pkg::PH_IDLE;
                end
            end
            default: ;
        endcase
        return n;
    endfunction

    // One byte of the open NAL unit: length, header, escape removal.
    function automatic t_state feed(input t_state s, input logic [7:0] b,
                                    output t_wr w);
        t_state n;
        n = s;
        w = '0;
        if (s.phase != sop_pkg::PH_SEARCH && s.phase != sop_pkg::PH_DONE) begin
            if (32'(s.ulen) <= MAX_UNIT_BYTES) n.ulen = s.ulen + ULW'(1);
            if (s.phase == sop_pkg::PH_NAL) begin
                n.phase = ((b[4:0] & sop_pkg::NAL_KIND_BITS) == sop_pkg::NAL_KIND_SEI)
                          ? sop_pkg::PH_UUID : sop_pkg::PH_IDLE;
                n.esc = '0;
            end else if (s.phase != sop_pkg::PH_IDLE) begin
                if (b == 8'd3 && s.esc >= 2'd2) begin
                    n.esc = '0;
                end else begin
                    n.esc = (b == 8'd0) ? ((s.esc >= 2'd2) ? 2'd2 : s.esc + 2'd1) : 2'd0;
                    n = parse_rbsp(n, b, w);
                end
            end
        end
        return n;
    endfunction

    // End of a NAL unit: commit a complete bank, else go back to search.
    function automatic t_state finish(input t_state s);
        t_state n;
        n = s;
        if (s.phase != sop_pkg::PH_SEARCH && s.phase != sop_pkg::PH_DONE) begin
            if (s.pcomp && 32'(s.ulen) <= MAX_UNIT_BYTES) begin
                n.abank = ~s.abank;
                n.cseq = s.pseq;
                n.cfrm = s.pfrm;
                n.udone = 1'b1;
                n.phase = sop_pkg::PH_DONE;
            end else begin
                n.phase = sop_pkg::PH_SEARCH;
            end
        end
        return n;
    endfunction

    // Start of a NAL unit: clear per-unit state.
    function automatic t_state start(input t_state s);
        t_state n;
        n = s;
        n.phase = sop_pkg::PH_NAL;
        n.ulen = '0;
        n.esc = '0;
        n.pat = '0;
        n.hdr = '0;
        n.pseq = '0;
        n.pfrm = '0;
        n.wp = '0;
        n.pcomp = 1'b0;
        return n;
    endfunction

    t_state     r_st, n_st;
    logic [7:0] r_dly [3];
    logic [7:0] n_dly [3];
    logic [1:0] r_fill, n_fill;

    logic       r_out_valid;
    logic       r_found, n_found;
    logic [5:0] r_cseq_out;
    logic [7:0] r_cfrm_out;
    logic       r_rd_ok, n_rd_ok;
    logic [1:0] r_rd_lane;
    logic [7:0] r_rd_data [NLANES];

    t_wr        wr [NSLOTS];
    logic       accept;
    logic       is_read;
    logic [13:0] rd_idx;
    logic [AW-1:0] rd_addr;

    assign i_in.ready = ~r_out_valid | o_out.ready;
    assign accept = i_in.valid & i_in.ready;
    assign is_read = (i_in.operation == sop_pkg::OP_READ);

    // Next parser state for a stream byte.
    always_comb begin
        t_state s;
        t_wr    w;
        s = r_st;
        w = '0;
        n_st = r_st;
        n_dly = r_dly;
        n_fill = r_fill;
        n_found = 1'b0;
        for (int i = 0; i < NSLOTS; i++) wr[i] = '0;
        if (!is_read) begin
            if (s.phase != sop_pkg::PH_DONE) begin
                if (r_fill >= 2'd2 && r_dly[1] == 8'd0 && r_dly[2] == 8'd0 &&
                    i_in.data_byte == 8'd1) begin
                    if (r_fill == 2'd3 && r_dly[0] != 8'd0) begin
                        s = feed(s, r_dly[0], w);
                        wr[0] = w;
                    end
                    s = finish(s);
                    if (s.phase != sop_pkg::PH_DONE) s = start(s);
                    n_fill = '0;
                    for (int i = 0; i < 3; i++) n_dly[i] = '0;
                end else begin
                    if (r_fill == 2'd3) begin
                        s = feed(s, r_dly[0], w);
                        wr[0] = w;
                    end
                    n_dly[0] = r_dly[1];
                    n_dly[1] = r_dly[2];
                    n_dly[2] = i_in.data_byte;
                    if (r_fill != 2'd3) n_fill = r_fill + 2'd1;
                end
            end
            if (i_in.last_byte) begin
                if (s.phase != sop_pkg::PH_DONE) begin
                    for (int k = 0; k < 3; k++) begin
                        if (k >= 3 - int'(n_fill)) begin
                            s = feed(s, n_dly[k], w);
                            wr[k + 1] = w;
                        end
                    end
                    s = finish(s);
                end
                n_found = s.udone;
                s = start(s);
                s.phase = sop_pkg::PH_SEARCH;
                s.udone = 1'b0;
                n_fill = '0;
                for (int i = 0; i < 3; i++) n_dly[i] = '0;
            end
            n_st = s;
        end
    end

    // Read address of a committed offset.
    always_comb begin
        rd_idx = 14'(i_in.sequence_index) * 14'(r_st.cfrm) + 14'(i_in.frame_index);
        n_rd_ok = (i_in.sequence_index < r_st.cseq) && (i_in.frame_index < r_st.cfrm) &&
                  (32'(rd_idx) < TABLE_DEPTH);
        rd_addr = AW'(32'(r_st.abank) * LANE_DEPTH + 32'(rd_idx >> 2));
    end

    // Four table memories, each written by at most one slot per cycle.
    for (genvar l = 0; l < NLANES; l++) begin : g_lane
        logic [7:0]    mem [2 * LANE_DEPTH];
        logic          we;
        logic [AW-1:0] waddr;
        logic [7:0]    wdata;

        always_comb begin
            we = 1'b0;
            waddr = '0;
            wdata = '0;
            for (int i = 0; i < NSLOTS; i++) begin
                if (wr[i].we && wr[i].pos[1:0] == 2'(l)) begin
                    we = 1'b1;
                    waddr = AW'(32'(wr[i].bank) * LANE_DEPTH + 32'(wr[i].pos >> 2));
                    wdata = wr[i].val;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (accept && !is_read && we) begin
                mem[waddr] <= wdata;
            end
            if (accept && is_read) begin
                r_rd_data[l] <= mem[rd_addr];
            end
        end
    end

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
            r_fill <= '0;
            for (int i = 0; i < 3; i++) r_dly[i] <= '0;
            r_out_valid <= 1'b0;
            r_found <= 1'b0;
            r_rd_ok <= 1'b0;
            r_cseq_out <= '0;
            r_cfrm_out <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_found <= n_found;
                r_rd_ok <= is_read & n_rd_ok;
                if (!is_read) begin
                    r_st <= n_st;
                    r_fill <= n_fill;
                    r_dly <= n_dly;
                    r_cseq_out <= n_st.cseq;
                    r_cfrm_out <= n_st.cfrm;
                end else begin
                    r_cseq_out <= r_st.cseq;
                    r_cfrm_out <= r_st.cfrm;
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_read) r_rd_lane <= rd_idx[1:0];
    end

    assign o_out.valid = r_out_valid;
    assign o_out.found = r_found;
    assign o_out.sequence_count = r_cseq_out;
    assign o_out.frame_count = r_cfrm_out;
    assign o_out.offset = r_rd_ok ? r_rd_data[r_rd_lane] : 8'sd0;

endmodule
